// ----- rtl/sdtq_pkg.sv -----
`default_nettype none
package sdtq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MAX_BURST = 16;
  // Burst counter holds 0..MAX_BURST; the pop buffer index drops the top bit.
  localparam int BW = 5;
  localparam int PW = 4;
  localparam logic [31:0] WAIT_NONE = 32'h7fff_ffff;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_ADD       = 3'd2,
    OP_DROP_KEY  = 3'd3,
    OP_DROP_OWN  = 3'd4,
    OP_EXPIRE    = 3'd5,
    OP_QUERY     = 3'd6,
    OP_BAD       = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic [31:0] deadline;
    logic [15:0] key;
    logic [15:0] owner;
    logic        periodic;
    logic [30:0] interval;
  } cmd_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [30:0] interval;
    logic [15:0] key;
    logic [15:0] owner;
    logic        periodic;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/sdtq_front.sv -----
`default_nettype none
module sdtq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [2:0]        opcode,
  input  wire logic [31:0]       now_ms,
  input  wire logic [15:0]       timer_key,
  input  wire logic [15:0]       owner_id,
  input  wire logic              periodic,
  input  wire logic [30:0]       interval_ms,
  output logic                   cmd_valid,
  input  wire logic              cmd_take,
  output sdtq_pkg::cmd_t         cmd
);

  sdtq_pkg::cmd_t q0;
  sdtq_pkg::cmd_t q1;
  sdtq_pkg::cmd_t incoming;
  logic [1:0]     cnt;
  logic           push;
  logic           pop;
  logic [1:0]     slot;

  // The add deadline wraps modulo 2^32, as does every deadline in the table.
  always_comb begin
    incoming.op       = sdtq_pkg::op_t'(opcode);
    incoming.now_ms   = now_ms;
    incoming.deadline = now_ms + {1'b0, interval_ms};
    incoming.key      = timer_key;
    incoming.owner    = owner_id;
    incoming.periodic = periodic;
    incoming.interval = interval_ms;
  end

  assign req_stall = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q0;
  assign push      = req_valid && !req_stall;
  assign pop       = cmd_take && cmd_valid;
  assign slot      = cnt - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= q1;
    end
    if (push) begin
      if (slot == 2'd0) begin
        q0 <= incoming;
      end else begin
        q1 <= incoming;
      end
    end
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sdtq_back.sv -----
`default_nettype none
module sdtq_back #(
  parameter int DEPTH = sdtq_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_take,
  input  wire sdtq_pkg::cmd_t    cmd,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic [1:0]             status,
  output logic                   went_first,
  output logic                   fired,
  output logic [15:0]            fired_key,
  output logic [15:0]            fired_owner,
  output logic [31:0]            wait_ms,
  output logic                   last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > sdtq_pkg::BW) ? CW : sdtq_pkg::BW;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_EMIT    = 16'h0002,
    S_INS_RD  = 16'h0004,
    S_INS_CHK = 16'h0008,
    S_INS_PUT = 16'h0010,
    S_CMP_RD  = 16'h0020,
    S_CMP_CHK = 16'h0040,
    S_EXP_RD  = 16'h0080,
    S_EXP_CHK = 16'h0100,
    S_EXP_DONE = 16'h0200,
    S_SHF_RD  = 16'h0400,
    S_SHF_WR  = 16'h0800,
    S_EXP_OUT = 16'h1000,
    S_RE_NEXT = 16'h2000,
    S_Q_RD    = 16'h4000,
    S_Q_CHK   = 16'h8000
  } state_t;

  state_t                  state;
  logic                    running;
  logic [CW-1:0]           count;
  sdtq_pkg::cmd_t          cmd_r;
  sdtq_pkg::entry_t        ins;
  logic [CW-1:0]           ri;
  logic [CW-1:0]           rp;
  logic [CW-1:0]           wp;
  logic                    found;
  logic                    from_exp;
  logic [sdtq_pkg::BW-1:0] n;
  logic [sdtq_pkg::BW-1:0] k;
  logic [1:0]              r_status;
  logic                    r_first;
  logic [15:0]             r_key;
  logic [31:0]             r_wait;

  sdtq_pkg::entry_t        mem [DEPTH];
  sdtq_pkg::entry_t        rd_data;
  sdtq_pkg::entry_t        pop_buf [sdtq_pkg::MAX_BURST];
  sdtq_pkg::entry_t        pop_k;

  logic                    mem_we;
  logic [IW-1:0]           mem_wa;
  sdtq_pkg::entry_t        mem_wd;
  logic [IW-1:0]           mem_ra;

  logic                    can_emit;
  logic                    drop;
  logic                    ins_less;
  logic [31:0]             re_sum;
  logic [31:0]             re_dl;
  logic [sdtq_pkg::BW-1:0] k_inc;

  assign can_emit = !rsp_valid || !rsp_stall;
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign pop_k    = pop_buf[k[sdtq_pkg::PW-1:0]];
  assign k_inc    = k + 1'b1;
  assign ins_less = ins.deadline < rd_data.deadline;
  assign re_sum   = pop_k.deadline + {1'b0, pop_k.interval};
  assign re_dl    = (re_sum < cmd_r.now_ms) ? cmd_r.now_ms : re_sum;
  // Remove by key drops only the first match; remove by owner drops them all.
  assign drop = (cmd_r.op == sdtq_pkg::OP_DROP_KEY) ? (!found && rd_data.key == cmd_r.key)
                                                    : (rd_data.owner == cmd_r.owner);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = IW'(wp);
    mem_wd = rd_data;
    mem_ra = '0;
    case (state)
      S_INS_RD:  mem_ra = IW'(ri - 1'b1);
      S_INS_CHK: begin
        mem_we = ins_less;
        mem_wa = IW'(ri);
      end
      S_INS_PUT: begin
        mem_we = 1'b1;
        mem_wa = IW'(ri);
        mem_wd = ins;
      end
      S_CMP_RD:  mem_ra = IW'(rp);
      S_CMP_CHK: mem_we = !drop;
      S_EXP_RD:  mem_ra = IW'(n);
      S_SHF_RD:  mem_ra = IW'(rp);
      S_SHF_WR:  mem_we = 1'b1;
      default:   mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_r    <= cmd;
          r_status <= sdtq_pkg::ST_OK;
          r_first  <= 1'b0;
          r_key    <= '0;
          r_wait   <= '0;
          state    <= S_EMIT;
          if (cmd.op == sdtq_pkg::OP_START) begin
            if (running) begin
              r_status <= sdtq_pkg::ST_REFUSED;
            end
            running <= 1'b1;
          end else if (cmd.op == sdtq_pkg::OP_BAD) begin
            r_status <= sdtq_pkg::ST_REFUSED;
          end else if (!running) begin
            r_status <= sdtq_pkg::ST_REFUSED;
            if (cmd.op == sdtq_pkg::OP_QUERY) begin
              r_wait <= sdtq_pkg::WAIT_NONE;
            end
          end else if (cmd.op == sdtq_pkg::OP_STOP) begin
            count   <= '0;
            running <= 1'b0;
          end else if (cmd.op == sdtq_pkg::OP_ADD) begin
            if (count == CW'(DEPTH)) begin
              r_status <= sdtq_pkg::ST_FULL;
              r_key    <= cmd.key;
            end else begin
              ins      <= '{cmd.deadline, cmd.interval, cmd.key, cmd.owner, cmd.periodic};
              ri       <= count;
              from_exp <= 1'b0;
              state    <= S_INS_RD;
            end
          end else if (cmd.op inside {sdtq_pkg::OP_DROP_KEY, sdtq_pkg::OP_DROP_OWN}) begin
            rp    <= '0;
            wp    <= '0;
            found <= 1'b0;
            state <= S_CMP_RD;
          end else if (cmd.op == sdtq_pkg::OP_EXPIRE) begin
            n     <= '0;
            state <= S_EXP_RD;
          end else if (count == '0) begin
            r_wait <= sdtq_pkg::WAIT_NONE;
          end else begin
            state <= S_Q_RD;
          end
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          rsp_valid   <= 1'b1;
          status      <= r_status;
          went_first  <= r_first;
          fired       <= 1'b0;
          fired_key   <= r_key;
          fired_owner <= '0;
          wait_ms     <= r_wait;
          last        <= 1'b1;
          state       <= S_IDLE;
        end
      end
      // Insertion walks down from the tail, moving every strictly later entry up one.
      S_INS_RD:  state <= (ri == '0) ? S_INS_PUT : S_INS_CHK;
      S_INS_CHK: begin
        if (ins_less) begin
          ri    <= ri - 1'b1;
          state <= S_INS_RD;
        end else begin
          state <= S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        count <= count + 1'b1;
        if (from_exp) begin
          state <= S_RE_NEXT;
        end else begin
          r_first <= (ri == '0);
          r_key   <= cmd_r.key;
          state   <= S_EMIT;
        end
      end
      S_CMP_RD: begin
        if (rp == count) begin
          count <= wp;
          state <= S_EMIT;
        end else begin
          state <= S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (drop) begin
          found <= 1'b1;
        end else begin
          wp <= wp + 1'b1;
        end
        rp    <= rp + 1'b1;
        state <= S_CMP_RD;
      end
      S_EXP_RD: begin
        if (n == sdtq_pkg::BW'(sdtq_pkg::MAX_BURST) || EW'(n) == EW'(count)) begin
          state <= S_EXP_DONE;
        end else begin
          state <= S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (!(cmd_r.now_ms < rd_data.deadline)) begin
          pop_buf[n[sdtq_pkg::PW-1:0]] <= rd_data;
          n     <= n + 1'b1;
          state <= S_EXP_RD;
        end else begin
          state <= S_EXP_DONE;
        end
      end
      S_EXP_DONE: begin
        if (n == '0) begin
          state <= S_EMIT;
        end else begin
          rp    <= CW'(n);
          wp    <= '0;
          state <= S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        if (rp == count) begin
          count <= wp;
          k     <= '0;
          state <= S_EXP_OUT;
        end else begin
          state <= S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        rp    <= rp + 1'b1;
        wp    <= wp + 1'b1;
        state <= S_SHF_RD;
      end
      S_EXP_OUT: begin
        if (can_emit) begin
          rsp_valid   <= 1'b1;
          status      <= sdtq_pkg::ST_OK;
          went_first  <= 1'b0;
          fired       <= 1'b1;
          fired_key   <= pop_k.key;
          fired_owner <= pop_k.owner;
          wait_ms     <= '0;
          last        <= (k_inc == n);
          if (pop_k.periodic) begin
            ins      <= '{re_dl, pop_k.interval, pop_k.key, pop_k.owner, 1'b1};
            ri       <= count;
            from_exp <= 1'b1;
            state    <= S_INS_RD;
          end else begin
            state <= S_RE_NEXT;
          end
        end
      end
      S_RE_NEXT: begin
        k     <= k_inc;
        state <= (k_inc == n) ? S_IDLE : S_EXP_OUT;
      end
      S_Q_RD:    state <= S_Q_CHK;
      S_Q_CHK: begin
        r_wait <= (rd_data.deadline > cmd_r.now_ms) ? rd_data.deadline - cmd_r.now_ms : '0;
        state  <= S_EMIT;
      end
      default:   state <= S_IDLE;
    endcase
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_deadline_timer_queue_top.sv -----
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  opcode now_ms timer_key owner_id periodic interval_ms
// rsp      out        rsp_valid/rsp_stall  status went_first fired fired_key fired_owner
//                                          wait_ms last
// An add moves each strictly later entry up one; a remove passes over every table entry;
// an expire reads the expired entries, shifts the rest down, emits one response per fired
// timer and does one insertion per periodic timer. The table memory has one write and one
// registered read per cycle.
// Reset clears the running flag and the entry count; the table itself is never cleared.
// A two-entry command queue takes requests while the table is busy or rsp stalls, until full.
module sorted_deadline_timer_queue_top #(
  parameter int DEPTH = sdtq_pkg::DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] timer_key,
  input  wire logic [15:0] owner_id,
  input  wire logic        periodic,
  input  wire logic [30:0] interval_ms,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic             went_first,
  output logic             fired,
  output logic [15:0]      fired_key,
  output logic [15:0]      fired_owner,
  output logic [31:0]      wait_ms,
  output logic             last
);

  logic           cmd_valid;
  logic           cmd_take;
  sdtq_pkg::cmd_t cmd;

  sdtq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .opcode      (opcode),
    .now_ms      (now_ms),
    .timer_key   (timer_key),
    .owner_id    (owner_id),
    .periodic    (periodic),
    .interval_ms (interval_ms),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .cmd         (cmd)
  );

  sdtq_back #(.DEPTH(DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_take    (cmd_take),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .went_first  (went_first),
    .fired       (fired),
    .fired_key   (fired_key),
    .fired_owner (fired_owner),
    .wait_ms     (wait_ms),
    .last        (last)
  );

  a_take_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid) else $error("back end took a command from an empty queue");

  a_fired_is_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fired |-> status == sdtq_pkg::ST_OK && wait_ms == '0 && !went_first)
    else $error("fired transaction carries a stray status or wait");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status == sdtq_pkg::ST_OK || status == sdtq_pkg::ST_REFUSED ||
                  status == sdtq_pkg::ST_FULL) else $error("undefined status code");

endmodule
`default_nettype wire
